@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file sas_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ hdl/sas_pkg.sv @@
// Package for the sensor alarm supervisor: widths, register indexes, types.
// No dependencies.
`timescale 1ns / 1ps

package sas_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METHANE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALL_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_DLY  = 3'd5;

    localparam logic [1:0] WARN_NONE    = 2'd0;
    localparam logic [1:0] WARN_RAISED  = 2'd1;
    localparam logic [1:0] WARN_CLEARED = 2'd2;

    typedef struct packed {
        logic [6:0]            battery_low_limit;
        logic [9:0]            methane_limit;
        logic [10:0]           tilt_limit;
        logic [12:0]           water_low_limit;
        logic [COUNT_BITS-1:0] hall_hold_ticks;
        logic [COUNT_BITS-1:0] recover_delay_ticks;
    } sas_cfg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] hall_count;
        logic                  hall_latched;
        logic                  alarm_flag;
        logic                  report_armed;
        logic                  recover_pending;
        logic [COUNT_BITS-1:0] recover_count;
        logic                  local_buzz_enable;
    } sas_state_t;

    typedef struct packed {
        logic        silence_cmd;
        logic [11:0] water_sample;
        logic [10:0] tilt_tenths;
        logic [9:0]  methane_tenths;
        logic [6:0]  battery_pct;
        logic        hall_level;
    } sas_item_t;

    typedef struct packed {
        logic [1:0] warn_change;
        logic       report_alarm;
        logic       report_now;
        logic       buzzer_on;
        logic       hall_confirmed;
        logic       alarm_active;
    } sas_result_t;

endpackage

@@ hdl/sas_step.sv @@
// One-tick decision logic: debounce, alarm, reports, buzzer and change code.
// Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_step
(
    input  sas_pkg::sas_cfg_t    cfg,
    input  sas_pkg::sas_state_t  state,
    input  sas_pkg::sas_item_t   item,
    output sas_pkg::sas_state_t  state_next,
    output sas_pkg::sas_result_t result
);
    import sas_pkg::*;

    logic [COUNT_BITS-1:0] hall_cnt;
    logic                  hall_conf;
    logic                  alarm;
    logic                  onset;
    logic                  pend1;
    logic [COUNT_BITS-1:0] rc1;
    logic                  delay_met;
    logic                  recovery;

    always_comb
    begin
        if (item.hall_level)
        begin
            hall_cnt  = (state.hall_count < CNT_MAX) ? state.hall_count + COUNT_BITS'(1)
                                                     : state.hall_count;
            hall_conf = state.hall_latched || (hall_cnt >= cfg.hall_hold_ticks);
        end
        else
        begin
            hall_cnt  = '0;
            hall_conf = 1'b0;
        end

        alarm = (item.battery_pct <= cfg.battery_low_limit)
             || (item.methane_tenths >= cfg.methane_limit)
             || (item.tilt_tenths >= cfg.tilt_limit)
             || ({1'b0, item.water_sample} < cfg.water_low_limit)
             || hall_conf;

        onset = alarm && state.report_armed;
        pend1 = state.recover_pending || onset;
        rc1   = (pend1 && state.recover_count < CNT_MAX) ? state.recover_count + COUNT_BITS'(1)
                                                         : state.recover_count;
        delay_met = pend1 && (rc1 >= cfg.recover_delay_ticks);
        recovery  = delay_met && !alarm;

        state_next.hall_count      = hall_cnt;
        state_next.hall_latched    = hall_conf;
        state_next.alarm_flag      = alarm;
        state_next.report_armed    = !alarm;
        state_next.recover_pending = pend1 && !recovery;
        if (!pend1 || recovery)
            state_next.recover_count = '0;
        else if (delay_met)
            state_next.recover_count = cfg.recover_delay_ticks;
        else
            state_next.recover_count = rc1;

        if (item.silence_cmd)
            state_next.local_buzz_enable = 1'b0;
        else if (!alarm)
            state_next.local_buzz_enable = 1'b1;
        else
            state_next.local_buzz_enable = state.local_buzz_enable;

        result.alarm_active   = alarm;
        result.hall_confirmed = hall_conf;
        result.buzzer_on      = !item.silence_cmd && alarm && state.local_buzz_enable;
        result.report_now     = onset || recovery;
        result.report_alarm   = onset;
        if (alarm == state.alarm_flag)
            result.warn_change = WARN_NONE;
        else if (alarm)
            result.warn_change = WARN_RAISED;
        else
            result.warn_change = WARN_CLEARED;
    end

endmodule

@@ hdl/sensor_alarm_supervisor_core.sv @@
// Sensor alarm supervisor top level: config registers, input and result stages.
// Depends on sas_pkg and sas_step.
//
//  channel  | signals                               | transaction
//  ---------+---------------------------------------+-----------------------
//  s_ (in)  | s_tvalid s_tready s_tdata[47:0]       | one 10 ms tick
//  m_ (out) | m_tvalid m_tready m_tdata[7:0]        | one result per tick
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data| one register write
//
// Each tick passes the input register, then the result register; one tick per cycle sustained while m_tready is high.
// The decision logic sits between the input register and the result register.
// Both stages advance together; a stalled result holds the input stage full.
// rst_n is asynchronous: state and limits return to their reset values.
// cfg_ready is always high; write only while no transaction is in flight.
`timescale 1ns / 1ps

module sensor_alarm_supervisor_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] hall_level, [7:1] battery_pct, [17:8] methane_tenths,
    // [28:18] tilt_tenths, [40:29] water_sample, [41] silence_cmd, [47:42] unused
    input  logic [sas_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] alarm_active, [1] hall_confirmed, [2] buzzer_on, [3] report_now,
    // [4] report_alarm, [6:5] warn_change, [7] zero
    output logic [sas_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sas_pkg::*;

    sas_cfg_t    cfg_reg;
    sas_state_t  state_reg;
    sas_state_t  state_next;
    sas_item_t   item_reg;
    logic        item_valid_reg;
    sas_result_t result_next;
    sas_result_t result_reg;
    logic        result_valid_reg;
    logic        advance;

    assign advance   = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = result_valid_reg;
    assign m_tdata   = {1'b0, result_reg};

    sas_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.battery_low_limit   <= 7'd5;
            cfg_reg.methane_limit       <= 10'd800;
            cfg_reg.tilt_limit          <= 11'd300;
            cfg_reg.water_low_limit     <= 13'd410;
            cfg_reg.hall_hold_ticks     <= COUNT_BITS'(500);
            cfg_reg.recover_delay_ticks <= COUNT_BITS'(500);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BATTERY_LOW: cfg_reg.battery_low_limit   <= cfg_data[6:0];
                REG_METHANE:     cfg_reg.methane_limit       <= cfg_data[9:0];
                REG_TILT:        cfg_reg.tilt_limit          <= cfg_data[10:0];
                REG_WATER_LOW:   cfg_reg.water_low_limit     <= cfg_data[12:0];
                REG_HALL_HOLD:   cfg_reg.hall_hold_ticks     <= cfg_data[COUNT_BITS-1:0];
                REG_RECOVER_DLY: cfg_reg.recover_delay_ticks <= cfg_data[COUNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hall_count        <= '0;
            state_reg.hall_latched      <= 1'b0;
            state_reg.alarm_flag        <= 1'b0;
            state_reg.report_armed      <= 1'b1;
            state_reg.recover_pending   <= 1'b0;
            state_reg.recover_count     <= '0;
            state_reg.local_buzz_enable <= 1'b1;
            item_valid_reg              <= 1'b0;
            result_valid_reg            <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (s_tvalid && s_tready)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (m_tready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_tdata[$bits(sas_item_t)-1:0];
        if (advance)
            result_reg <= result_next;
    end

endmodule

@@ hdl/sas_checker.sv @@
// Port-level checker for the sensor alarm supervisor, bound to the top level.
// Depends on sas_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sas_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sas_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import sas_pkg::*;

    // an alarm-flagged report is always a requested report
    `ASSERT_IMPL(a_rep_alarm_needs_rep, clk, rst_n, m_tvalid && m_tdata[4], m_tdata[3])
    // change code is never the unused value
    `ASSERT_IMPL(a_warn_code, clk, rst_n, m_tvalid, m_tdata[6:5] != 2'd3)
    // buzzer and confirmed hall both imply an active alarm
    `ASSERT_IMPL(a_buzz_alarm, clk, rst_n, m_tvalid && m_tdata[2], m_tdata[0])
    `ASSERT_IMPL(a_hall_alarm, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[0])
    // stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sensor_alarm_supervisor_core sas_checker u_sas_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
